/* hw/rtl/pmrat_pkg.sv */
// Shared types and codes for the reservation admission table.
// Used by every module of the block and by the port checker.
package pmrat_pkg;

	localparam int OP_W     = 2;
	localparam int HOLDER_W = 32;
	localparam int KIND_W   = 2;
	localparam int VM_W     = 8;
	localparam int MASK_W   = 4;
	localparam int CNT_W    = 7;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_ACQUIRE     = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE     = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE_ALL = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BUSY         = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_RESERVED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_ROOM      = 2'd3;

	localparam logic RSV_DEVICE  = 1'b0;
	localparam logic RSV_CONTEXT = 1'b1;

	localparam logic [MASK_W-1:0] MASK_RESET = 4'd3;
	localparam logic [CNT_W-1:0]  CNT_MAX    = 7'd127;

	// s_tdata layout
	localparam int I_HOLDER = 0;
	localparam int I_KIND   = 32;
	localparam int I_SCOPE  = 34;
	localparam int I_VM     = 35;
	localparam int IN_W     = 48;

	// m_tdata layout
	localparam int O_STATUS  = 0;
	localparam int O_REMOVED = 2;
	localparam int O_PULSE   = 9;
	localparam int O_GATE    = 10;
	localparam int O_REFCNT  = 11;
	localparam int OUT_W     = 24;

	typedef struct packed {
		logic                scope;
		logic [VM_W-1:0]     vm;
		logic [HOLDER_W-1:0] holder;
	} entry_t;

	typedef struct packed {
		logic hit;     // same holder and vm, slot in use
		logic vm_hit;  // same vm, slot in use
		logic busy;    // slot blocks an acquire
		logic free;    // slot not in use
	} match_t;

endpackage

/* hw/rtl/pm_reservation_admission_table_core.sv */
// Reservation admission table: top level with the scan sequencer.
// Depends on pmrat_pkg, pmrat_slot_mem and pmrat_match.
//
// Usage:
//  s_* carries request words: s_tuser is the operation (acquire, release,
//  release-all); s_tdata holds holder id, kind, scope and vm. m_* carries
//  one result word per request: status, removed count, unit reset pulse,
//  gating value and the shared monitor refcount.
//  cfg_we/cfg_wdata write the counted type mask; write it only while idle.
//  One request at a time: s_tready is high only while the sequencer idles.
//  Acquire and release scan the slots of one kind, one slot per cycle through
//  the slot memory read port and the compare unit. Release-all scans every
//  slot. Unknown operations, and acquire or release with a kind out of range,
//  skip the scan and go straight to the final step. s_tready returns with
//  m_tvalid.
//  The result sits in an output register; a new request is taken while it
//  waits, and the next result holds in the final step until m_tready frees it.
//  Reset empties every slot, zeroes the refcount and sets the mask to 3.
module pm_reservation_admission_table_core import pmrat_pkg::*; #(
	parameter int KIND_COUNT     = 4,
	parameter int SLOTS_PER_KIND = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // holder_id, resource_kind, reserve_scope, vm_number
	input  logic [OP_W-1:0]   s_tuser,   // operation
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // status, removed_count, unit_reset_pulse,
	                                     // gating_enable, shared_refcount
	input  logic              cfg_we,
	input  logic [MASK_W-1:0] cfg_wdata
);

	localparam int TOTAL = KIND_COUNT * SLOTS_PER_KIND;
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int SW    = (SLOTS_PER_KIND > 1) ? $clog2(SLOTS_PER_KIND) : 1;
	localparam int KW    = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS_PER_KIND - 1);
	localparam logic [KW-1:0] LAST_KIND = KW'(KIND_COUNT - 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;

	logic [MASK_W-1:0]   mask_q;
	logic [OP_W-1:0]     op_q;
	logic [HOLDER_W-1:0] holder_q;
	logic [KIND_W-1:0]   kind_q;
	logic                scope_q;
	logic [VM_W-1:0]     vm_q;
	logic                kind_ok_q;

	logic [AW-1:0] addr_q;
	logic [SW-1:0] slot_q;
	logic [KW-1:0] kcnt_q;

	logic          valid_s1;
	logic [AW-1:0] addr_s1;
	logic [KW-1:0] kind_s1;

	logic [TOTAL-1:0] used_q;
	logic             busy_q;
	logic             found_q;
	logic [AW-1:0]    found_idx_q;
	logic             free_q;
	logic [AW-1:0]    free_idx_q;
	logic [CNT_W-1:0] rm_cnt_q;
	logic             pulse_q;
	logic [CNT_W-1:0] refcnt_q;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	entry_t rd_entry;
	entry_t wr_entry;
	match_t m;

	logic [KIND_W-1:0] in_kind;
	logic              in_kind_ok;
	logic [AW-1:0]     in_base;
	logic [3:0]        kind_s1_ext;
	logic              s1_counted;

	logic                fin_go;
	logic [STATUS_W-1:0] fin_status;
	logic [CNT_W-1:0]    fin_removed;
	logic                fin_pulse;
	logic                fin_gate;
	logic [CNT_W-1:0]    rc_next;
	logic                set_used;
	logic                clr_used;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign in_kind    = s_tdata[I_KIND +: KIND_W];
	assign in_kind_ok = (int'(in_kind) < KIND_COUNT);
	assign in_base    = AW'(int'(in_kind) * SLOTS_PER_KIND);

	assign kind_s1_ext = 4'(kind_s1);
	assign s1_counted  = (kind_s1_ext < 4'd4) && mask_q[kind_s1_ext[1:0]];

	assign wr_entry = '{scope: scope_q, vm: vm_q, holder: holder_q};

	pmrat_slot_mem #(.DEPTH(TOTAL), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (fin_go && set_used),
		.waddr (free_idx_q),
		.wdata (wr_entry),
		.raddr (addr_q),
		.rdata (rd_entry)
	);

	pmrat_match u_match (
		.used       (used_q[addr_s1]),
		.entry      (rd_entry),
		.req_holder (holder_q),
		.req_vm     (vm_q),
		.req_scope  (scope_q),
		.m          (m)
	);

	assign fin_go = (state_q == S_FINISH) && (!out_valid_q || m_tready);

	always_comb begin
		fin_status  = ST_OK;
		fin_removed = '0;
		fin_pulse   = 1'b0;
		fin_gate    = 1'b0;
		rc_next     = refcnt_q;
		set_used    = 1'b0;
		clr_used    = 1'b0;
		case (op_q)
			OP_ACQUIRE: begin
				if (!kind_ok_q || (!busy_q && !free_q)) begin
					fin_status = ST_NO_ROOM;
				end else if (busy_q) begin
					fin_status = ST_BUSY;
				end else begin
					set_used = 1'b1;
					if (mask_q[kind_q]) begin
						if (refcnt_q != CNT_MAX) begin
							rc_next = refcnt_q + CNT_W'(1);
						end
						fin_pulse = (rc_next == CNT_W'(1));
					end
				end
			end
			OP_RELEASE: begin
				if (kind_ok_q && found_q) begin
					clr_used    = 1'b1;
					fin_removed = CNT_W'(1);
					if (mask_q[kind_q] && refcnt_q != '0) begin
						rc_next   = refcnt_q - CNT_W'(1);
						fin_pulse = (rc_next == '0);
						fin_gate  = fin_pulse;
					end
				end else begin
					fin_status = ST_NOT_RESERVED;
				end
			end
			OP_RELEASE_ALL: begin
				fin_removed = rm_cnt_q;
				fin_pulse   = pulse_q;
				fin_gate    = pulse_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	// request capture and scan counters
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q      <= s_tuser;
			holder_q  <= s_tdata[I_HOLDER +: HOLDER_W];
			kind_q    <= in_kind;
			scope_q   <= s_tdata[I_SCOPE];
			vm_q      <= s_tdata[I_VM +: VM_W];
			kind_ok_q <= in_kind_ok;
			addr_q    <= (s_tuser == OP_RELEASE_ALL) ? '0 : in_base;
			slot_q    <= '0;
			kcnt_q    <= '0;
		end else if (state_q == S_SCAN) begin
			addr_q <= addr_q + AW'(1);
			if (slot_q == LAST_SLOT) begin
				slot_q <= '0;
				kcnt_q <= kcnt_q + KW'(1);
			end else begin
				slot_q <= slot_q + SW'(1);
			end
		end
		addr_s1 <= addr_q;
		kind_s1 <= kcnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == S_SCAN);
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if ((s_tuser == OP_ACQUIRE || s_tuser == OP_RELEASE) && in_kind_ok) begin
							state_q <= S_SCAN;
						end else if (s_tuser == OP_RELEASE_ALL) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SCAN: begin
					if (slot_q == LAST_SLOT &&
						(op_q != OP_RELEASE_ALL || kcnt_q == LAST_KIND)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// compare stage, slot bits and refcount
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			busy_q   <= 1'b0;
			found_q  <= 1'b0;
			free_q   <= 1'b0;
			rm_cnt_q <= '0;
			pulse_q  <= 1'b0;
			refcnt_q <= '0;
		end else if (s_tvalid && s_tready) begin
			busy_q   <= 1'b0;
			found_q  <= 1'b0;
			free_q   <= 1'b0;
			rm_cnt_q <= '0;
			pulse_q  <= 1'b0;
		end else if (fin_go) begin
			refcnt_q <= rc_next;
			if (set_used) begin
				used_q[free_idx_q] <= 1'b1;
			end
			if (clr_used) begin
				used_q[found_idx_q] <= 1'b0;
			end
		end else if (valid_s1) begin
			case (op_q)
				OP_ACQUIRE: begin
					if (m.busy) begin
						busy_q <= 1'b1;
					end
					if (m.free && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= addr_s1;
					end
				end
				OP_RELEASE: begin
					if (m.hit && !found_q) begin
						found_q     <= 1'b1;
						found_idx_q <= addr_s1;
					end
				end
				OP_RELEASE_ALL: begin
					if (m.vm_hit) begin
						used_q[addr_s1] <= 1'b0;
						if (rm_cnt_q != CNT_MAX) begin
							rm_cnt_q <= rm_cnt_q + CNT_W'(1);
						end
						if (s1_counted && refcnt_q != '0) begin
							refcnt_q <= refcnt_q - CNT_W'(1);
							if (refcnt_q == CNT_W'(1)) begin
								pulse_q <= 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_data_q <= OUT_W'({rc_next, fin_gate, fin_pulse, fin_removed, fin_status});
		end
	end

endmodule

/* hw/rtl/pmrat_slot_mem.sv */
// Slot storage: holder id, vm and scope of every reservation slot.
// One write port, one registered read port. Uses pmrat_pkg.
module pmrat_slot_mem import pmrat_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/pmrat_match.sv */
// Shared compare unit: checks one slot against the pending request.
// Uses pmrat_pkg types.
module pmrat_match import pmrat_pkg::*; (
	input  logic                used,
	input  entry_t              entry,
	input  logic [HOLDER_W-1:0] req_holder,
	input  logic [VM_W-1:0]     req_vm,
	input  logic                req_scope,
	output match_t              m
);

	logic vm_eq;
	logic id_eq;

	always_comb begin
		vm_eq    = (entry.vm == req_vm);
		id_eq    = vm_eq && (entry.holder == req_holder);
		m.hit    = used && id_eq;
		m.vm_hit = used && vm_eq;
		m.busy   = used && ((req_scope == RSV_DEVICE) || (entry.scope == RSV_DEVICE) || id_eq);
		m.free   = !used;
	end

endmodule

/* hw/rtl/pmrat_checker.sv */
// Port-level checks for the reservation admission table, bound to the top.
// Uses the m_tdata layout from pmrat_pkg.
module pmrat_checker import pmrat_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// one request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_gate_needs_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[O_GATE] |-> m_tdata[O_PULSE])
		else $error("gating set without unit reset");

	// pulse with gating off marks the first reference, gating on the last
	a_pulse_refcount: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[O_PULSE] |->
		(m_tdata[O_GATE] && m_tdata[O_REFCNT +: CNT_W] == '0) ||
		(!m_tdata[O_GATE] && m_tdata[O_REFCNT +: CNT_W] == CNT_W'(1)))
		else $error("unit reset pulse does not match refcount");

	a_refused_removes_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[O_STATUS +: STATUS_W] == ST_BUSY ||
		m_tdata[O_STATUS +: STATUS_W] == ST_NO_ROOM) |->
		m_tdata[O_REMOVED +: CNT_W] == '0 && !m_tdata[O_PULSE])
		else $error("refused acquire changed state");

endmodule

bind pm_reservation_admission_table_core pmrat_checker u_pmrat_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
